### design/rfid_inventory_frame_dedup_macros.svh
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef RFID_INVENTORY_FRAME_DEDUP_MACROS_SVH
`define RFID_INVENTORY_FRAME_DEDUP_MACROS_SVH

// same-cycle implication
`define RFD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfd assertion failed");

// next-cycle implication
`define RFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfd assertion failed");

`endif

### design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - package
// Constants, codes and the command/status types shared by the block.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int MAX_TAG_ENTRIES = 16;
  localparam int MAX_EPC_BYTES   = 15;
  localparam int FRAME_LIMIT     = 64;
  localparam int HDR_LEN         = 5;
  localparam int EPC_OFFSET      = 8;
  localparam int PAYLOAD_OVH     = 5;

  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int POS_W   = 7;
  localparam int MEM_DEPTH = MAX_TAG_ENTRIES * MAX_EPC_BYTES;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int PADDR_W = 5;

  localparam logic [7:0] START_BYTE = 8'hBB;
  localparam logic [7:0] TAIL_BYTE  = 8'h7E;

  localparam logic [7:0]  RST_NOTIFY = 8'd2;
  localparam logic [7:0]  RST_INV    = 8'd34;
  localparam logic [15:0] RST_TOTAL  = 16'd3000;
  localparam logic [15:0] RST_IDLE   = 16'd500;
  localparam logic [9:0]  RST_GAP    = 10'd100;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_TOTAL = 2'd1,
    CAUSE_IDLE  = 2'd2,
    CAUSE_FULL  = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    REG_NOTIFY = 3'd0,
    REG_INV    = 3'd1,
    REG_TOTAL  = 3'd2,
    REG_IDLE   = 3'd3,
    REG_GAP    = 3'd4
  } reg_e;

  typedef struct packed {
    logic [7:0]  notify_type_code;
    logic [7:0]  inventory_code;
    logic [15:0] scan_limit_ms;
    logic [15:0] idle_scan_ms;
    logic [9:0]  byte_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [SLOT_W-1:0] tag_slot;
    logic [3:0]       epc_length;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       epc_byte;
    logic             checksum_bad;
    logic [1:0]       end_cause;
    logic [CNT_W-1:0] tags_found;
    logic             last;
  } out_t;

  typedef struct packed {
    logic take;
    logic srch_init;
    logic next_slot;
    logic next_byte;
    logic emit_init;
    logic emit_beat;
    logic fin_beat;
  } cmd_t;

  typedef struct packed {
    logic frame_go;
    logic fin_go;
    logic slot_done;
    logic len_match;
    logic len_zero;
    logic byte_eq;
    logic byte_last;
    logic out_free;
    logic tbl_full;
  } sts_t;

endpackage

### design/rfd_if.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - channel interfaces
// Input and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface rfd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] tag_slot;
  logic [3:0] epc_length;
  logic [3:0] byte_index;
  logic [7:0] epc_byte;
  logic       checksum_bad;
  logic [1:0] end_cause;
  logic [4:0] tags_found;
  logic       last;
  modport source (output valid, kind, tag_slot, epc_length, byte_index, epc_byte,
                  checksum_bad, end_cause, tags_found, last, input ready);
  modport sink   (input valid, kind, tag_slot, epc_length, byte_index, epc_byte,
                  checksum_bad, end_cause, tags_found, last, output ready);
endinterface

### design/rfd_datapath.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - datapath
// Frame gathering, scan timers, tag table memory and result register.
// ----------------------------------------------------------------------------
module rfd_datapath
  import rfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  output out_t       out_data_o,
  input  logic       out_ready_i
);

  logic             scanning_q;
  logic [POS_W-1:0] fp_q;
  logic [7:0]       hdr_q [HDR_LEN];
  logic [7:0]       sum_q;
  logic             bad_q;
  logic [7:0]       epc_q [MAX_EPC_BYTES];
  logic [3:0]       tlen_q [MAX_TAG_ENTRIES];
  logic [CNT_W-1:0] tcnt_q;
  logic [15:0]      elap_q, since_q;
  logic [9:0]       gap_q;
  logic [1:0]       cause_q;
  logic [3:0]       len_q;
  logic [SLOT_W-1:0] s_q;
  logic [IDX_W-1:0] i_q;
  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rdata_q;
  logic             ovalid_q;
  out_t             odata_q;

  logic        take, is_byte, is_tick, is_start;
  logic [15:0] pl, elap_inc, since_inc;
  logic [16:0] p_ext, p5pl;
  logic [9:0]  gap_inc;
  logic        gap_drop, fin_total, fin_idle;
  logic        in_hdr, in_pay, at_sum, hdr_bad4, epc_wr, pl_ok, full;
  logic [IDX_W-1:0] epc_idx;
  logic [ADDR_W-1:0] addr;
  logic [7:0]  b;

  always_comb begin
    b        = rx_byte_i;
    take     = cmd_i.take && in_valid_i;
    is_start = take && (action_i == ACT_START);
    is_byte  = take && scanning_q && (action_i == ACT_BYTE);
    is_tick  = take && scanning_q && (action_i == ACT_TICK);
    pl       = {hdr_q[3], hdr_q[4]};
    p_ext    = 17'(fp_q);
    p5pl     = 17'(HDR_LEN) + 17'(pl);
    in_hdr   = fp_q < POS_W'(HDR_LEN);
    in_pay   = !in_hdr && (p_ext < p5pl);
    at_sum   = !in_hdr && (p_ext == p5pl);
    hdr_bad4 = (hdr_q[0] != START_BYTE) ||
               ((17'd7 + 17'({hdr_q[3], b})) > 17'(FRAME_LIMIT));
    epc_wr   = in_pay && (fp_q >= POS_W'(EPC_OFFSET)) &&
               ((fp_q - POS_W'(EPC_OFFSET)) < POS_W'(MAX_EPC_BYTES));
    epc_idx  = IDX_W'(fp_q - POS_W'(EPC_OFFSET));
    pl_ok    = (pl >= 16'(PAYLOAD_OVH)) && (pl <= 16'(PAYLOAD_OVH + MAX_EPC_BYTES));
    elap_inc = (elap_q == 16'hFFFF) ? elap_q : elap_q + 16'd1;
    since_inc = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
    gap_inc  = (gap_q == 10'h3FF) ? gap_q : gap_q + 10'd1;
    gap_drop = (fp_q != '0) && (gap_inc >= cfg_i.byte_gap_ms);
    fin_total = elap_inc >= cfg_i.scan_limit_ms;
    fin_idle  = since_inc >= cfg_i.idle_scan_ms;
    full     = tcnt_q == CNT_W'(MAX_TAG_ENTRIES);
    addr     = ADDR_W'(s_q) * ADDR_W'(MAX_EPC_BYTES) + ADDR_W'(i_q);

    sts_o.fin_go    = is_tick && (fin_total || fin_idle);
    sts_o.frame_go  = is_byte && !in_hdr && !in_pay && !at_sum && (b == TAIL_BYTE) &&
                      (hdr_q[1] == cfg_i.notify_type_code) &&
                      (hdr_q[2] == cfg_i.inventory_code) && pl_ok &&
                      (tcnt_q < CNT_W'(MAX_TAG_ENTRIES));
    sts_o.slot_done = {1'b0, s_q} == tcnt_q;
    sts_o.len_match = tlen_q[s_q] == len_q;
    sts_o.len_zero  = len_q == 4'd0;
    sts_o.byte_eq   = rdata_q == epc_q[i_q];
    sts_o.byte_last = (len_q == 4'd0) || (i_q == IDX_W'(len_q - 4'd1));
    sts_o.out_free  = !ovalid_q || out_ready_i;
    sts_o.tbl_full  = full;
  end

  // frame, timer and table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      fp_q       <= '0;
      sum_q      <= '0;
      bad_q      <= 1'b0;
      tcnt_q     <= '0;
      elap_q     <= '0;
      since_q    <= '0;
      gap_q      <= '0;
      cause_q    <= CAUSE_NONE;
    end else if (cmd_i.fin_beat) begin
      scanning_q <= 1'b0;
      fp_q       <= '0;
    end else if (cmd_i.emit_init) begin
      tcnt_q  <= tcnt_q + CNT_W'(1);
      since_q <= '0;
      cause_q <= CAUSE_FULL;
    end else if (is_start) begin
      scanning_q <= 1'b1;
      fp_q       <= '0;
      sum_q      <= '0;
      bad_q      <= 1'b0;
      tcnt_q     <= '0;
      elap_q     <= '0;
      since_q    <= '0;
      gap_q      <= '0;
    end else if (is_byte) begin
      gap_q <= '0;
      if (in_hdr) begin
        fp_q  <= fp_q + POS_W'(1);
        sum_q <= (fp_q == '0) ? 8'h00 : sum_q + b;
        if ((fp_q == POS_W'(HDR_LEN - 1)) && hdr_bad4) begin
          fp_q <= '0;
        end
      end else if (in_pay) begin
        sum_q <= sum_q + b;
        fp_q  <= fp_q + POS_W'(1);
      end else if (at_sum) begin
        bad_q <= b != sum_q;
        fp_q  <= fp_q + POS_W'(1);
      end else begin
        fp_q <= '0;
      end
    end else if (is_tick) begin
      elap_q  <= elap_inc;
      since_q <= since_inc;
      cause_q <= fin_total ? CAUSE_TOTAL : CAUSE_IDLE;
      if (fp_q != '0) begin
        if (gap_drop) begin
          fp_q  <= '0;
          gap_q <= '0;
        end else begin
          gap_q <= gap_inc;
        end
      end
    end
  end

  // header and EPC capture, search counters
  always_ff @(posedge clk_i) begin
    if (is_byte && in_hdr) begin
      hdr_q[fp_q[2:0]] <= b;
    end
    if (is_byte && epc_wr) begin
      epc_q[epc_idx] <= b;
    end
    if (sts_o.frame_go) begin
      len_q <= 4'(pl - 16'(PAYLOAD_OVH));
    end
    if (cmd_i.emit_init) begin
      tlen_q[s_q] <= len_q;
    end
    if (cmd_i.srch_init) begin
      s_q <= '0;
      i_q <= '0;
    end else if (cmd_i.next_slot) begin
      s_q <= s_q + SLOT_W'(1);
      i_q <= '0;
    end else if (cmd_i.next_byte || cmd_i.emit_beat) begin
      i_q <= i_q + IDX_W'(1);
    end else if (cmd_i.emit_init) begin
      i_q <= '0;
    end
  end

  // tag table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_beat && !sts_o.len_zero) begin
      mem[addr] <= epc_q[i_q];
    end
    rdata_q <= mem[addr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_beat || cmd_i.fin_beat) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_beat) begin
      odata_q.kind         <= 1'b0;
      odata_q.tag_slot     <= s_q;
      odata_q.epc_length   <= len_q;
      odata_q.byte_index   <= i_q;
      odata_q.epc_byte     <= sts_o.len_zero ? 8'h00 : epc_q[i_q];
      odata_q.checksum_bad <= bad_q;
      odata_q.end_cause    <= CAUSE_NONE;
      odata_q.tags_found   <= tcnt_q;
      odata_q.last         <= sts_o.byte_last && !full;
    end else if (cmd_i.fin_beat) begin
      odata_q.kind         <= 1'b1;
      odata_q.tag_slot     <= '0;
      odata_q.epc_length   <= '0;
      odata_q.byte_index   <= '0;
      odata_q.epc_byte     <= '0;
      odata_q.checksum_bad <= 1'b0;
      odata_q.end_cause    <= cause_q;
      odata_q.tags_found   <= tcnt_q;
      odata_q.last         <= 1'b1;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

### design/rfd_ctrl.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - controller
// Sequences input intake, the table search, tag emission and scan end.
// ----------------------------------------------------------------------------
`include "rfid_inventory_frame_dedup_macros.svh"

module rfd_ctrl
  import rfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o,
  input  logic in_valid_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_CK   = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = 1'b1;
        if (sts_i.frame_go) begin
          cmd_o.srch_init = 1'b1;
          state_d = ST_RD;
        end else if (sts_i.fin_go) begin
          state_d = ST_FIN;
        end
      end
      ST_RD: begin
        if (sts_i.slot_done) begin
          cmd_o.emit_init = 1'b1;
          state_d = ST_EMIT;
        end else if (!sts_i.len_match) begin
          cmd_o.next_slot = 1'b1;
        end else if (sts_i.len_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CK;
        end
      end
      ST_CK: begin
        if (!sts_i.byte_eq) begin
          cmd_o.next_slot = 1'b1;
          state_d = ST_RD;
        end else if (sts_i.byte_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.next_byte = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_beat = 1'b1;
          if (sts_i.byte_last) begin
            state_d = sts_i.tbl_full ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_beat = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `RFD_ASSERT(a_beat_needs_room, cmd_o.emit_beat || cmd_o.fin_beat, sts_i.out_free)
  `RFD_ASSERT(a_ck_after_rd, state_q == ST_CK, $past(state_q) == ST_RD)
  `RFD_ASSERT_NEXT(a_fin_then_idle, cmd_o.fin_beat, state_q == ST_IDLE)
  `RFD_ASSERT_NEXT(a_frame_starts_search, in_valid_i && in_ready_o && sts_i.frame_go,
                   state_q == ST_RD)

endmodule

### design/rfid_inventory_frame_dedup.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - top level
// Reader frame deframer with sum check and EPC tag table for inventory scans.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries one beat per event: a received UART byte, a millisecond tick
//   or a start-scan command. out_m carries results: one beat per EPC byte of
//   each new tag (one beat for an empty EPC), and one scan-ended beat with its
//   cause; last marks the final beat caused by an input beat.
//   The APB port holds the frame codes and the three timeouts; write it only
//   while the block is idle.
// Sequencing:
//   A beat that starts no table walk and no result is taken while the block
//   is idle. The tail byte of an inventory frame starts a walk that tests the
//   length of each stored tag and, where it matches, compares its EPC bytes
//   in turn. A new tag is then emitted byte by byte, and a scan end gives
//   one more beat; the next input waits for all of it.
// Reset and stalls:
//   Reset stops any scan and restores register defaults. The result register
//   holds a beat until taken; while it stalls the block finishes intake of the
//   current input and waits before loading the next beat.
// ----------------------------------------------------------------------------
module rfid_inventory_frame_dedup
  import rfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  rfd_in_if.sink             in_s,
  rfd_out_if.source          out_m,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  out_t odata;
  logic ovalid;
  logic apb_wr;
  reg_e ridx;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign ridx   = reg_e'(paddr[PADDR_W-1:2]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.notify_type_code <= RST_NOTIFY;
      cfg_q.inventory_code   <= RST_INV;
      cfg_q.scan_limit_ms    <= RST_TOTAL;
      cfg_q.idle_scan_ms     <= RST_IDLE;
      cfg_q.byte_gap_ms      <= RST_GAP;
    end else if (apb_wr) begin
      case (ridx)
        REG_NOTIFY: cfg_q.notify_type_code <= pwdata[7:0];
        REG_INV:    cfg_q.inventory_code   <= pwdata[7:0];
        REG_TOTAL:  cfg_q.scan_limit_ms    <= pwdata[15:0];
        REG_IDLE:   cfg_q.idle_scan_ms     <= pwdata[15:0];
        REG_GAP:    cfg_q.byte_gap_ms      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_NOTIFY: prdata = 32'(cfg_q.notify_type_code);
      REG_INV:    prdata = 32'(cfg_q.inventory_code);
      REG_TOTAL:  prdata = 32'(cfg_q.scan_limit_ms);
      REG_IDLE:   prdata = 32'(cfg_q.idle_scan_ms);
      REG_GAP:    prdata = 32'(cfg_q.byte_gap_ms);
      default:    prdata = '0;
    endcase
  end

  rfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_s.ready),
    .in_valid_i (in_s.valid)
  );

  rfd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_s.valid),
    .action_i    (in_s.action),
    .rx_byte_i   (in_s.rx_byte),
    .out_valid_o (ovalid),
    .out_data_o  (odata),
    .out_ready_i (out_m.ready)
  );

  assign out_m.valid        = ovalid;
  assign out_m.kind         = odata.kind;
  assign out_m.tag_slot     = odata.tag_slot;
  assign out_m.epc_length   = odata.epc_length;
  assign out_m.byte_index   = odata.byte_index;
  assign out_m.epc_byte     = odata.epc_byte;
  assign out_m.checksum_bad = odata.checksum_bad;
  assign out_m.end_cause    = odata.end_cause;
  assign out_m.tags_found   = odata.tags_found;
  assign out_m.last         = odata.last;

endmodule

### verif/rfd_frame_checker.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - scoreboard
// Watches the input, result and APB ports, predicts the tag and scan-ended
// beats of every accepted input beat and compares them in order.
// ----------------------------------------------------------------------------
module rfd_frame_checker
  import rfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  rfd_in_if                  in_w,
  rfd_out_if                 out_w,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 errors_o,
  output int                 pending_o,
  output logic               scan_on_o
);

  cfg_t        cfg;
  logic        scanning;
  int unsigned frame_pos;
  logic [7:0]  hdr [HDR_LEN];
  logic [7:0]  sum;
  logic        sum_bad;
  logic [7:0]  epc_buf [MAX_EPC_BYTES];
  logic [7:0]  tag_mem [MAX_TAG_ENTRIES][MAX_EPC_BYTES];
  int unsigned tag_len [MAX_TAG_ENTRIES];
  int unsigned tag_cnt;
  int unsigned elapsed_ms, since_new_ms, gap_ms;
  out_t        beats_due [$];
  out_t        step_beats [$];

  assign pending_o = beats_due.size();
  assign scan_on_o = scanning;

  function automatic void add_beat(logic kind, int unsigned slot, int unsigned len,
                                   int unsigned idx, logic [7:0] b, logic bad,
                                   cause_e cause);
    out_t r;
    r.kind         = kind;
    r.tag_slot     = slot[SLOT_W-1:0];
    r.epc_length   = len[3:0];
    r.byte_index   = idx[IDX_W-1:0];
    r.epc_byte     = b;
    r.checksum_bad = bad;
    r.end_cause    = cause;
    r.tags_found   = tag_cnt[CNT_W-1:0];
    r.last         = 1'b0;
    step_beats.push_back(r);
  endfunction

  function automatic void end_scan(cause_e cause);
    scanning  = 1'b0;
    frame_pos = 0;
    add_beat(1'b1, 0, 0, 0, 8'h00, 1'b0, cause);
  endfunction

  function automatic int unsigned payload_len();
    return {hdr[3], hdr[4]};
  endfunction

  function automatic void close_frame();
    int unsigned pl, len, slot;
    bit known;
    pl = payload_len();
    if (hdr[1] != cfg.notify_type_code || hdr[2] != cfg.inventory_code) return;
    if (pl < PAYLOAD_OVH || pl - PAYLOAD_OVH > MAX_EPC_BYTES) return;
    len   = pl - PAYLOAD_OVH;
    known = 1'b0;
    for (int s = 0; s < tag_cnt; s++) begin
      if (tag_len[s] == len) begin
        bit same;
        same = 1'b1;
        for (int i = 0; i < len; i++)
          if (tag_mem[s][i] != epc_buf[i]) same = 1'b0;
        if (same) known = 1'b1;
      end
    end
    if (known || tag_cnt >= MAX_TAG_ENTRIES) return;
    slot = tag_cnt;
    for (int i = 0; i < len; i++) tag_mem[slot][i] = epc_buf[i];
    tag_len[slot] = len;
    tag_cnt++;
    since_new_ms = 0;
    if (len == 0) add_beat(1'b0, slot, 0, 0, 8'h00, sum_bad, CAUSE_NONE);
    else
      for (int i = 0; i < len; i++)
        add_beat(1'b0, slot, len, i, epc_buf[i], sum_bad, CAUSE_NONE);
    if (tag_cnt >= MAX_TAG_ENTRIES) end_scan(CAUSE_FULL);
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned pl;
    gap_ms = 0;
    if (frame_pos < HDR_LEN) begin
      hdr[frame_pos] = b;
      sum = (frame_pos == 0) ? 8'h00 : sum + b;
      frame_pos++;
      if (frame_pos == HDR_LEN &&
          (hdr[0] != START_BYTE || 7 + payload_len() > FRAME_LIMIT))
        frame_pos = 0;
      return;
    end
    pl = payload_len();
    if (frame_pos < HDR_LEN + pl) begin
      sum = sum + b;
      if (frame_pos >= EPC_OFFSET && frame_pos - EPC_OFFSET < MAX_EPC_BYTES)
        epc_buf[frame_pos - EPC_OFFSET] = b;
      frame_pos++;
    end else if (frame_pos == HDR_LEN + pl) begin
      sum_bad = (b != sum);
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (b == TAIL_BYTE) close_frame();
    end
  endfunction

  function automatic void take_tick();
    if (elapsed_ms < 65535) elapsed_ms++;
    if (since_new_ms < 65535) since_new_ms++;
    if (frame_pos > 0) begin
      if (gap_ms < 1023) gap_ms++;
      if (gap_ms >= cfg.byte_gap_ms) begin
        frame_pos = 0;
        gap_ms    = 0;
      end
    end
    if (elapsed_ms >= cfg.scan_limit_ms) end_scan(CAUSE_TOTAL);
    else if (since_new_ms >= cfg.idle_scan_ms) end_scan(CAUSE_IDLE);
  endfunction

  function automatic void predict_beat(logic [1:0] act, logic [7:0] b);
    step_beats.delete();
    if (act == ACT_START) begin
      scanning     = 1'b1;
      frame_pos    = 0;
      sum          = 8'h00;
      sum_bad      = 1'b0;
      tag_cnt      = 0;
      elapsed_ms   = 0;
      since_new_ms = 0;
      gap_ms       = 0;
      return;
    end
    if (!scanning) return;
    if (act == ACT_BYTE) take_byte(b);
    else if (act == ACT_TICK) take_tick();
    if (step_beats.size() > 0) step_beats[$].last = 1'b1;
    foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
  endfunction

  function automatic void check_beat(out_t got);
    out_t want;
    if (beats_due.size() == 0) begin
      errors_o++;
      if (errors_o <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = beats_due.pop_front();
    if (got.kind != want.kind || got.tag_slot != want.tag_slot ||
        got.epc_length != want.epc_length || got.byte_index != want.byte_index ||
        got.epc_byte != want.epc_byte || got.checksum_bad != want.checksum_bad ||
        got.end_cause != want.end_cause || got.tags_found != want.tags_found ||
        got.last != want.last) begin
      errors_o++;
      if (errors_o <= 10) $display("result mismatch: expected %p, got %p", want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg          <= '{RST_NOTIFY, RST_INV, RST_TOTAL, RST_IDLE, RST_GAP};
      scanning     <= 1'b0;
      frame_pos    <= 0;
      sum          <= 8'h00;
      sum_bad      <= 1'b0;
      tag_cnt      <= 0;
      elapsed_ms   <= 0;
      since_new_ms <= 0;
      gap_ms       <= 0;
      errors_o     <= 0;
      beats_due.delete();
    end else begin
      if (out_w.valid && out_w.ready)
        check_beat('{out_w.kind, out_w.tag_slot, out_w.epc_length, out_w.byte_index,
                     out_w.epc_byte, out_w.checksum_bad, out_w.end_cause,
                     out_w.tags_found, out_w.last});
      if (in_w.valid && in_w.ready) predict_beat(in_w.action, in_w.rx_byte);
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:2]))
          REG_NOTIFY: cfg.notify_type_code = pwdata[7:0];
          REG_INV:    cfg.inventory_code   = pwdata[7:0];
          REG_TOTAL:  cfg.scan_limit_ms    = pwdata[15:0];
          REG_IDLE:   cfg.idle_scan_ms     = pwdata[15:0];
          REG_GAP:    cfg.byte_gap_ms      = pwdata[9:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### verif/tb_rfid_inventory_frame_dedup.sv
// ----------------------------------------------------------------------------
// RFID inventory frame dedup - testbench top
// Drives reader frames, ticks and scan starts through several register
// settings; the scoreboard beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_rfid_inventory_frame_dedup;
  import rfd_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;
  int                 errors, pending, sent;
  logic               scan_on;
  bit                 steady;     // no idling on either side while set
  logic [7:0]         notify_now, inv_now;
  logic [7:0]         epc_pool [8][$];

  rfd_in_if  in_c ();
  rfd_out_if out_c ();

  rfid_inventory_frame_dedup uut (
    .clk_i, .rst_ni, .in_s(in_c), .out_m(out_c),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rfd_frame_checker scoreboard (
    .clk_i, .rst_ni, .in_w(in_c), .out_w(out_c),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors_o(errors), .pending_o(pending), .scan_on_o(scan_on)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // result side stalls at random, about 9 percent of the time
  always @(posedge clk_i)
    out_c.ready <= steady || ($urandom_range(99) >= 9);

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #40000000;
    $display("tb_rfid_inventory_frame_dedup: done, errors");
    $finish;
  end

  // Send one input beat; entered and left at a rising edge.
  task automatic send_beat(logic [1:0] act, logic [7:0] b);
    if (!steady)
      while ($urandom_range(99) < 9) begin
        in_c.valid <= 1'b0;
        @(posedge clk_i);
      end
    in_c.valid   <= 1'b1;
    in_c.action  <= act;
    in_c.rx_byte <= b;
    forever begin
      @(negedge clk_i);
      if (in_c.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sent++;
  endtask

  task automatic tick(int n);
    repeat (n) send_beat(ACT_TICK, 8'($urandom_range(255)));
  endtask

  // Hold until every predicted beat has come, then let a table walk finish.
  task automatic drain();
    in_c.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (r == REG_NOTIFY) notify_now = v[7:0];
    if (r == REG_INV) inv_now = v[7:0];
  endtask

  task automatic set_regs(logic [7:0] nt, logic [7:0] iv, logic [15:0] tot,
                          logic [15:0] idl, logic [9:0] gap);
    drain();
    write_reg(REG_NOTIFY, 32'(nt));
    write_reg(REG_INV, 32'(iv));
    write_reg(REG_TOTAL, 32'(tot));
    write_reg(REG_IDLE, 32'(idl));
    write_reg(REG_GAP, 32'(gap));
  endtask

  // Send a whole frame; optionally spoil the sum or tail, and slip ticks in
  // after a random byte to exercise the byte gap timer.
  task automatic send_frame(logic [7:0] typ, logic [7:0] cmd, logic [7:0] body[$],
                            bit bad_sum, bit bad_tail, int mid_ticks);
    logic [7:0]  q[$];
    logic [7:0]  s;
    logic [15:0] n;
    int          cut;
    n = 16'(body.size());
    s = typ + cmd + n[15:8] + n[7:0];
    foreach (body[i]) s += body[i];
    q = {START_BYTE, typ, cmd, n[15:8], n[7:0]};
    q = {q, body};
    q.push_back(bad_sum ? s ^ (8'h01 << $urandom_range(7)) : s);
    q.push_back(bad_tail ? TAIL_BYTE ^ (8'h01 << $urandom_range(7)) : TAIL_BYTE);
    cut = $urandom_range(q.size() - 2);
    foreach (q[i]) begin
      send_beat(ACT_BYTE, q[i]);
      if (i == cut) tick(mid_ticks);
    end
  endtask

  task automatic tag_frame(logic [7:0] epc[$], bit bad_sum, bit bad_tail, int mid_ticks);
    logic [7:0] body[$];
    body = {8'($urandom), 8'($urandom), 8'($urandom)};
    body = {body, epc};
    send_frame(notify_now, inv_now, body, bad_sum, bad_tail, mid_ticks);
  endtask

  function automatic void fresh_epc(ref logic [7:0] epc[$], input int len);
    epc.delete();
    repeat (len) epc.push_back(8'($urandom));
  endfunction

  initial begin
    logic [7:0] epc[$];
    logic [7:0] body[$];
    int         pick;
    int         phase_start;
    in_c.valid   <= 1'b0;
    in_c.action  <= ACT_BYTE;
    in_c.rx_byte <= 8'h00;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    steady     = 1'b0;
    sent       = 0;
    notify_now = RST_NOTIFY;
    inv_now    = RST_INV;
    foreach (epc_pool[i]) fresh_epc(epc_pool[i], (i == 0) ? 0 : $urandom_range(1, 15));
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle block ignores bytes and ticks; unknown action ignored.
    send_beat(ACT_BYTE, 8'hFF);
    send_beat(ACT_TICK, 8'h00);
    send_beat(2'd3, 8'hAA);
    send_beat(ACT_START, 8'h00);
    tag_frame(epc_pool[1], 0, 0, 0);      // new tag
    tag_frame(epc_pool[1], 0, 0, 0);      // duplicate, dropped
    tag_frame(epc_pool[2], 1, 0, 0);      // sum mismatch, still kept
    tag_frame(epc_pool[0], 0, 0, 0);      // empty EPC field, too short for a tag
    tag_frame(epc_pool[3], 0, 1, 0);      // broken tail
    send_frame(notify_now ^ 8'h01, inv_now, {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66},
               0, 0, 0);                  // other frame type
    send_frame(notify_now, inv_now, {8'h01, 8'h02, 8'h03, 8'h04}, 0, 0, 0);  // short
    fresh_epc(body, 21);
    send_frame(notify_now, inv_now, body, 0, 0, 0);                // EPC too long
    body = {8'hBA, 8'h02, 8'h22, 8'h00, 8'h05};
    foreach (body[i]) send_beat(ACT_BYTE, body[i]);                // bad start byte
    body = {8'hBB, 8'h02, 8'h22, 8'h00, 8'h3A};
    foreach (body[i]) send_beat(ACT_BYTE, body[i]);                // too long
    send_beat(ACT_START, 8'h00);          // restart mid-scan clears the table
    tag_frame(epc_pool[1], 0, 0, 0);

    // Extremes of the timeouts: each ends the scan on the first tick.
    set_regs(8'd0, 8'd255, 16'd1, 16'd65535, 10'd1);
    send_beat(ACT_START, 8'h00);
    tick(1);
    set_regs(8'd255, 8'd0, 16'd65535, 16'd1, 10'd1000);
    send_beat(ACT_START, 8'h00);
    tick(1);

    // Seventeen frames with one-byte EPC fields; each payload is too short to hold a tag.
    set_regs(8'd255, 8'd0, 16'd65535, 16'd65535, 10'd1000);
    send_beat(ACT_START, 8'h00);
    for (int t = 0; t < 17; t++) begin
      epc = {8'(t)};
      tag_frame(epc, t[0], 0, 0);
    end

    // Byte gap: a tight gap drops a frame broken by silence.
    set_regs(8'd2, 8'd34, 16'd65535, 16'd65535, 10'd2);
    send_beat(ACT_START, 8'h00);
    tag_frame(epc_pool[4], 0, 0, 2);
    tag_frame(epc_pool[4], 0, 0, 1);

    // Random phases, each with its own setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(8'($urandom), 8'($urandom), 16'd60, 16'd20, 10'd3);
        1: set_regs(8'd2, 8'd34, 16'd3000, 16'd500, 10'd100);
        2: set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(20, 90)),
                    16'($urandom_range(5, 30)), 10'($urandom_range(1, 4)));
        default: set_regs(8'hFF, 8'h00, 16'd65535, 16'($urandom_range(8, 40)), 10'd1000);
      endcase
      send_beat(ACT_START, 8'h00);
      phase_start = sent;
      while (sent < phase_start + ((ph == 2) ? 25 : 5)) begin
        steady = (ph == 2);
        if (!scan_on || $urandom_range(99) < 2) send_beat(ACT_START, 8'h00);
        pick = $urandom_range(99);
        if (pick < 60) begin
          tag_frame(epc_pool[$urandom_range(7)], $urandom_range(99) < 15,
                    $urandom_range(99) < 5,
                    ($urandom_range(99) < 10) ? $urandom_range(1, 4) : 0);
        end else if (pick < 80) begin
          fresh_epc(epc, $urandom_range(0, 15));
          tag_frame(epc, $urandom_range(99) < 15, 0, 0);
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 6)) send_beat(ACT_BYTE, 8'($urandom));
        end else if (pick < 94) begin
          fresh_epc(body, $urandom_range(0, 8));
          send_frame(8'($urandom), 8'($urandom), body, 0, 0, 0);
        end else begin
          send_beat(2'd3, 8'($urandom));
        end
        tick($urandom_range(0, 3));
        if ($urandom_range(99) < 3) drain();
      end
    end
    steady = 1'b0;

    drain();
    if (errors == 0) $display("tb_rfid_inventory_frame_dedup: done, clean");
    else $display("tb_rfid_inventory_frame_dedup: done, errors");
    $finish;
  end

endmodule
